@@ design/tlvsd_pkg.sv @@
// tlvsd_pkg: shared constants, codes and result type of the tlv stream decoder
// no dependencies; imported by the parser, the top level and the bench
`timescale 1ns / 1ps

package tlvsd_pkg;

  localparam logic [7:0] TAG_ZERO     = 8'h00;
  localparam logic [7:0] TAG_RSVD_7F  = 8'h7F;
  localparam logic [7:0] TAG_RSVD_80  = 8'h80;
  localparam logic [7:0] TAG_ONES     = 8'hFF;

  localparam logic [7:0] LEN_EXT_ONE  = 8'h81;
  localparam logic [7:0] LEN_EXT_TWO  = 8'h82;
  localparam logic [7:0] LEN_EXT_UNSP = 8'h83;

  typedef enum logic [1:0] {
    ERR_BAD_TAG   = 2'd0,
    ERR_TAG_MISM  = 2'd1,
    ERR_LEN_FORM  = 2'd2,
    ERR_TRUNCATED = 2'd3
  } err_code_e;

  typedef struct packed {
    logic        has_res;
    logic        is_value;
    logic [7:0]  value_byte;
    logic        done_res;
    logic        error;
    logic [1:0]  error_code;
    logic [7:0]  tag_seen;
    logic [15:0] value_length;
  } tlvsd_res_t;

endpackage

@@ design/tlvsd_if.sv @@
// tlvsd_in_if / tlvsd_out_if: valid/ready channels for raw bytes and decode results
// depends on nothing but the port widths of the decoder
`timescale 1ns / 1ps

interface tlvsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface tlvsd_out_if;
  logic        valid;
  logic        ready;
  logic        is_value;
  logic [7:0]  value_byte;
  logic        done_res;
  logic        error;
  logic [1:0]  error_code;
  logic [7:0]  tag_seen;
  logic [15:0] value_length;

  modport source (
    output valid, output is_value, output value_byte, output done_res,
    output error, output error_code, output tag_seen, output value_length,
    input ready
  );
  modport sink (
    input valid, input is_value, input value_byte, input done_res,
    input error, input error_code, input tag_seen, input value_length,
    output ready
  );
endinterface

@@ design/tlvsd_parser.sv @@
// tlvsd_parser: tlv header/value state machine, one byte per step
// depends on tlvsd_pkg; result is combinational from the held state and the staged byte
`timescale 1ns / 1ps

module tlvsd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  input  logic [7:0]           expected_tag_i,
  output tlvsd_pkg::tlvsd_res_t res_o
);
  import tlvsd_pkg::*;

  typedef enum logic [2:0] {
    PH_TAG    = 3'd0,
    PH_LEN    = 3'd1,
    PH_LEN1   = 3'd2,
    PH_LEN2HI = 3'd3,
    PH_LEN2LO = 3'd4,
    PH_VALUE  = 3'd5,
    PH_SKIP   = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  tag_q, tag_d;
  logic [15:0] len_q, len_d;
  logic [15:0] left_q, left_d;

  logic        fail;
  err_code_e   fail_code;
  logic        hdr_done;
  logic [15:0] hdr_len;
  logic [15:0] left_dec;
  logic        bad_tag;

  assign left_dec = left_q - 16'd1;
  assign bad_tag  = (byte_i == TAG_ZERO) || (byte_i == TAG_RSVD_7F) ||
                    (byte_i == TAG_RSVD_80) || (byte_i == TAG_ONES);

  always_comb begin
    phase_d   = phase_q;
    tag_d     = tag_q;
    len_d     = len_q;
    left_d    = left_q;
    fail      = 1'b0;
    fail_code = ERR_BAD_TAG;
    hdr_done  = 1'b0;
    hdr_len   = 16'd0;
    res_o     = '0;

    unique case (phase_q)
      PH_TAG: begin
        tag_d  = byte_i;
        len_d  = 16'd0;
        left_d = 16'd0;
        if ((expected_tag_i != TAG_ZERO) && (byte_i != expected_tag_i)) begin
          fail      = 1'b1;
          fail_code = ERR_TAG_MISM;
        end else if (bad_tag) begin
          fail      = 1'b1;
          fail_code = ERR_BAD_TAG;
        end else if (last_i) begin
          fail      = 1'b1;
          fail_code = ERR_TRUNCATED;
        end else begin
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        if (byte_i == LEN_EXT_UNSP) begin
          fail      = 1'b1;
          fail_code = ERR_LEN_FORM;
        end else if ((byte_i == LEN_EXT_ONE) || (byte_i == LEN_EXT_TWO)) begin
          if (last_i) begin
            fail      = 1'b1;
            fail_code = ERR_TRUNCATED;
          end else begin
            phase_d = (byte_i == LEN_EXT_ONE) ? PH_LEN1 : PH_LEN2HI;
          end
        end else begin
          hdr_done = 1'b1;
          hdr_len  = {8'd0, byte_i};
        end
      end
      PH_LEN1: begin
        hdr_done = 1'b1;
        hdr_len  = {8'd0, byte_i};
      end
      PH_LEN2HI: begin
        len_d = {byte_i, 8'd0};
        if (last_i) begin
          fail      = 1'b1;
          fail_code = ERR_TRUNCATED;
        end else begin
          phase_d = PH_LEN2LO;
        end
      end
      PH_LEN2LO: begin
        hdr_done = 1'b1;
        hdr_len  = {len_q[15:8], byte_i};
      end
      PH_VALUE: begin
        left_d            = left_dec;
        res_o.has_res     = 1'b1;
        res_o.is_value    = 1'b1;
        res_o.value_byte  = byte_i;
        if (left_dec == 16'd0) begin
          res_o.done_res = 1'b1;
          phase_d        = last_i ? PH_TAG : PH_SKIP;
        end else if (last_i) begin
          res_o.error      = 1'b1;
          res_o.error_code = ERR_TRUNCATED;
          phase_d          = PH_TAG;
        end
      end
      PH_SKIP: begin
        if (last_i) begin
          phase_d = PH_TAG;
        end
      end
      default: begin
        phase_d = PH_TAG;
      end
    endcase

    if (hdr_done) begin
      len_d = hdr_len;
      if (hdr_len == 16'd0) begin
        res_o.has_res  = 1'b1;
        res_o.done_res = 1'b1;
        phase_d        = last_i ? PH_TAG : PH_SKIP;
      end else begin
        left_d = hdr_len;
        if (last_i) begin
          res_o.has_res    = 1'b1;
          res_o.error      = 1'b1;
          res_o.error_code = ERR_TRUNCATED;
          phase_d          = PH_TAG;
        end else begin
          phase_d = PH_VALUE;
        end
      end
    end

    if (fail) begin
      res_o.has_res    = 1'b1;
      res_o.error      = 1'b1;
      res_o.error_code = fail_code;
      phase_d          = last_i ? PH_TAG : PH_SKIP;
    end

    res_o.tag_seen     = tag_d;
    res_o.value_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      tag_q   <= 8'd0;
      len_q   <= 16'd0;
      left_q  <= 16'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      left_q  <= left_d;
    end
  end

endmodule

@@ design/tlv_stream_decoder.sv @@
// tlv_stream_decoder: top level, input stage, parser and result register
// depends on tlvsd_pkg, tlvsd_in_if, tlvsd_out_if and tlvsd_parser
`timescale 1ns / 1ps

// usage:
//   in_i carries the buffer one byte per transfer, in_last marking its final byte.
//   out_o carries one result per value byte, per done event or per error; header
//   bytes and bytes after done or an error give no result.
//   cfg_we_i / cfg_wdata_i write expected_tag (zero accepts any supported tag);
//   write it only while no byte is in flight.
//   a byte accepted into the input stage register passes through the parser into the
//   result register; throughput: one byte per cycle while out_o is not stalled, the
//   parser step sitting between the input stage register and the result register.
//   when the receiver stalls, one pending result and one staged byte are held;
//   in_i.ready falls only while both are full and out_o.ready is low.
//   reset clears expected_tag, the parser state (expecting a tag) and both
//   valid flags; no result is lost or repeated across a stall.

module tlv_stream_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  tlvsd_in_if.sink           in_i,
  tlvsd_out_if.source        out_o
);
  import tlvsd_pkg::*;

  logic       exp_tag_q;
  logic [7:0] expected_tag_q;
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       out_vld_q;
  logic       out_free;
  logic       step;
  tlvsd_res_t res;
  tlvsd_res_t res_q;

  assign out_free   = !out_vld_q || out_o.ready;
  assign step       = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || step;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_tag_q <= 8'd0;
      exp_tag_q      <= 1'b0;
    end else if (cfg_we_i) begin
      expected_tag_q <= cfg_wdata_i;
      exp_tag_q      <= (cfg_wdata_i != TAG_ZERO);
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.in_byte;
      last_q <= in_i.in_last;
    end
  end

  tlvsd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .byte_i         (byte_q),
    .last_i         (last_q),
    .expected_tag_i (exp_tag_q ? expected_tag_q : TAG_ZERO),
    .res_o          (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && res.has_res) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.has_res) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.is_value     = res_q.is_value;
  assign out_o.value_byte   = res_q.value_byte;
  assign out_o.done_res     = res_q.done_res;
  assign out_o.error        = res_q.error;
  assign out_o.error_code   = res_q.error_code;
  assign out_o.tag_seen     = res_q.tag_seen;
  assign out_o.value_length = res_q.value_length;

endmodule

@@ sim/tlv_stream_decoder_tb.sv @@
// tlv_stream_decoder_tb: self-checking bench for the tlv stream decoder, directed then random buffers
// depends on tlvsd_pkg, tlvsd_in_if, tlvsd_out_if and tlv_stream_decoder from the design folder
`timescale 1ns / 1ps

module tlv_stream_decoder_tb;
  import tlvsd_pkg::*;

  typedef enum int {
    SEEK_TAG, READ_LEN, READ_LEN1, READ_LEN_HI, READ_LEN_LO, READ_VALUE, DISCARD
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_byte_t;

  typedef struct {
    bit        is_value;
    bit [7:0]  value_byte;
    bit        done;
    bit        err;
    err_code_e code;
    bit [7:0]  tag;
    bit [15:0] len;
  } decode_res_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  tlvsd_in_if  in_if ();
  tlvsd_out_if out_if ();

  tlv_stream_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  raw_byte_t   tx_bytes[$];
  logic [7:0]  frame_bytes[$];
  decode_res_t pending_results[$];

  parse_phase_e ph = SEEK_TAG;
  logic [7:0]   want_tag = 8'h00;
  logic [7:0]   tag_r = 8'h00;
  logic [15:0]  len_r = 16'h0000;
  logic [15:0]  left_r = 16'h0000;

  bit src_idle = 1'b1;
  bit snk_idle = 1'b1;
  int src_wait = 0;
  int snk_wait = 0;
  int hold_req = 0;
  int hold_cnt = 0;

  int mismatches = 0;
  int bytes_sent = 0;
  int buffers_queued = 0;
  int results_seen = 0;
  int dones_seen = 0;
  int errors_seen = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.in_last = 1'b0;
    out_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // predictor

  function void push_result(bit isv, logic [7:0] vb, bit done, bit err, err_code_e code);
    decode_res_t r;
    r.is_value   = isv;
    r.value_byte = isv ? vb : 8'h00;
    r.done       = done;
    r.err        = err;
    r.code       = err ? code : ERR_BAD_TAG;
    r.tag        = tag_r;
    r.len        = len_r;
    pending_results.push_back(r);
  endfunction

  function void abort_parse(bit last, err_code_e code);
    ph = last ? SEEK_TAG : DISCARD;
    push_result(1'b0, 8'h00, 1'b0, 1'b1, code);
  endfunction

  function void close_header(bit last);
    if (len_r == 16'h0000) begin
      ph = last ? SEEK_TAG : DISCARD;
      push_result(1'b0, 8'h00, 1'b1, 1'b0, ERR_BAD_TAG);
    end else begin
      left_r = len_r;
      if (last) begin
        ph = SEEK_TAG;
        push_result(1'b0, 8'h00, 1'b0, 1'b1, ERR_TRUNCATED);
      end else begin
        ph = READ_VALUE;
      end
    end
  endfunction

  function void parse_byte(logic [7:0] b, bit last);
    case (ph)
      SEEK_TAG: begin
        tag_r  = b;
        len_r  = 16'h0000;
        left_r = 16'h0000;
        if (want_tag != 8'h00 && b != want_tag) abort_parse(last, ERR_TAG_MISM);
        else if (b == TAG_ZERO || b == TAG_RSVD_7F || b == TAG_RSVD_80 || b == TAG_ONES)
          abort_parse(last, ERR_BAD_TAG);
        else if (last) abort_parse(last, ERR_TRUNCATED);
        else ph = READ_LEN;
      end
      READ_LEN: begin
        if (b == LEN_EXT_UNSP) abort_parse(last, ERR_LEN_FORM);
        else if (b == LEN_EXT_ONE || b == LEN_EXT_TWO) begin
          if (last) abort_parse(last, ERR_TRUNCATED);
          else ph = (b == LEN_EXT_ONE) ? READ_LEN1 : READ_LEN_HI;
        end else begin
          len_r = {8'h00, b};
          close_header(last);
        end
      end
      READ_LEN1: begin
        len_r = {8'h00, b};
        close_header(last);
      end
      READ_LEN_HI: begin
        len_r = {b, 8'h00};
        if (last) abort_parse(last, ERR_TRUNCATED);
        else ph = READ_LEN_LO;
      end
      READ_LEN_LO: begin
        len_r[7:0] = b;
        close_header(last);
      end
      READ_VALUE: begin
        left_r = left_r - 16'd1;
        if (left_r == 16'h0000) begin
          ph = last ? SEEK_TAG : DISCARD;
          push_result(1'b1, b, 1'b1, 1'b0, ERR_BAD_TAG);
        end else if (last) begin
          ph = SEEK_TAG;
          push_result(1'b1, b, 1'b0, 1'b1, ERR_TRUNCATED);
        end else begin
          push_result(1'b1, b, 1'b0, 1'b0, ERR_BAD_TAG);
        end
      end
      default: if (last) ph = SEEK_TAG;
    endcase
  endfunction

  function int idle_draw(bit enabled);
    if (enabled && $urandom_range(0, 2) == 0) return $urandom_range(0, 18);
    return 0;
  endfunction

  function void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // byte source

  always @(posedge clk) begin : byte_driver
    raw_byte_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      src_wait = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        parse_byte(in_if.in_byte, in_if.in_last);
        bytes_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_wait > 0) begin
          src_wait--;
          in_if.valid <= 1'b0;
        end else if (tx_bytes.size() > 0) begin
          nxt = tx_bytes.pop_front();
          in_if.valid   <= 1'b1;
          in_if.in_byte <= nxt.data;
          in_if.in_last <= nxt.last;
          src_wait = idle_draw(src_idle);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result sink and checker

  always @(posedge clk) begin : result_monitor
    decode_res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: tag %0h value %0h",
                 out_if.tag_seen, out_if.value_byte);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("is_value", 16'(want.is_value), 16'(out_if.is_value));
          check_field("value_byte", 16'(want.value_byte), 16'(out_if.value_byte));
          check_field("done_res", 16'(want.done), 16'(out_if.done_res));
          check_field("error", 16'(want.err), 16'(out_if.error));
          check_field("error_code", 16'(want.code), 16'(out_if.error_code));
          check_field("tag_seen", 16'(want.tag), 16'(out_if.tag_seen));
          check_field("value_length", want.len, out_if.value_length);
          if (want.done) dones_seen++;
          if (want.err) errors_seen++;
        end
        snk_wait = idle_draw(snk_idle);
      end
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else if (snk_wait > 0) begin
        snk_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // stimulus

  task automatic frame_flush();
    foreach (frame_bytes[i])
      tx_bytes.push_back('{data: frame_bytes[i], last: (i == frame_bytes.size() - 1)});
    if (frame_bytes.size() > 0) buffers_queued++;
    frame_bytes.delete();
  endtask

  task automatic frame_junk(int n);
    repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (tx_bytes.size() != 0 || in_if.valid || pending_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_expected_tag(logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    want_tag = v;
  endtask

  function automatic logic [7:0] pick_tag();
    logic [7:0] t;
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 && want_tag != 8'h00) begin
      t = want_tag;
    end else if (r < 6) begin
      do t = 8'($urandom_range(1, 254));
      while (t == TAG_RSVD_7F || t == TAG_RSVD_80);
    end else if (r < 8) begin
      t = 8'($urandom_range(0, 255));
    end else begin
      case ($urandom_range(0, 3))
        0: t = TAG_ZERO;
        1: t = TAG_RSVD_7F;
        2: t = TAG_RSVD_80;
        default: t = TAG_ONES;
      endcase
    end
    return t;
  endfunction

  task automatic random_buffer();
    logic [15:0] len;
    int hdr;
    int nval;
    int t;
    if ($urandom_range(0, 19) == 0) begin
      frame_junk($urandom_range(1, 4));
    end else begin
      frame_bytes.push_back(pick_tag());
      case ($urandom_range(0, 9))
        0: begin
          t = $urandom_range(0, 124);
          len = (t == 0) ? 16'h0080 : 16'h0083 + 16'(t);
          frame_bytes.push_back(len[7:0]);
        end
        1: begin
          len = 16'($urandom_range(0, 255));
          frame_bytes.push_back(LEN_EXT_ONE);
          frame_bytes.push_back(len[7:0]);
        end
        2: begin
          len = $urandom_range(0, 1) ? 16'($urandom_range(0, 6))
                                     : 16'($urandom_range(0, 65535));
          frame_bytes.push_back(LEN_EXT_TWO);
          frame_bytes.push_back(len[15:8]);
          frame_bytes.push_back(len[7:0]);
        end
        3: begin
          len = 16'h0000;
          frame_bytes.push_back(LEN_EXT_UNSP);
        end
        default: begin
          len = 16'($urandom_range(0, 8));
          frame_bytes.push_back(len[7:0]);
        end
      endcase
      hdr = frame_bytes.size();
      if (len > 16) nval = $urandom_range(0, 4);
      else if ($urandom_range(0, 7) == 0) nval = $urandom_range(0, len);
      else nval = int'(len);
      frame_junk(nval);
      if ($urandom_range(0, 11) == 0)
        while (frame_bytes.size() > $urandom_range(1, hdr)) void'(frame_bytes.pop_back());
      if ($urandom_range(0, 3) == 0) frame_junk($urandom_range(1, 3));
    end
    frame_flush();
  endtask

  initial begin : stimulus
    logic [7:0] phase_tags[6];
    phase_tags = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h00, 8'h00};
    phase_tags[4] = 8'($urandom_range(0, 255));
    wait (rst_n === 1'b1);
    write_expected_tag(8'h00);

    // any tag accepted
    frame_bytes = '{8'h01, 8'h00};                      frame_flush();
    frame_bytes = '{8'hFE, 8'h02, 8'h00, 8'hFF, 8'h5A}; frame_flush();
    frame_bytes = '{TAG_ZERO};                          frame_flush();
    frame_bytes = '{TAG_RSVD_7F};                       frame_flush();
    frame_bytes = '{TAG_RSVD_80};                       frame_flush();
    frame_bytes = '{TAG_ONES};                          frame_flush();
    frame_bytes = '{8'h7E, LEN_EXT_UNSP, 8'h11};        frame_flush();
    frame_bytes = '{8'h10, LEN_EXT_ONE, 8'h01, 8'hAA};  frame_flush();
    frame_bytes = '{8'h22, LEN_EXT_TWO, 8'h00, 8'h00};  frame_flush();
    // buffer ends inside the header, then inside the value
    frame_bytes = '{8'h20};                             frame_flush();
    frame_bytes = '{8'h20, LEN_EXT_TWO};                frame_flush();
    frame_bytes = '{8'h30, 8'h05, 8'hC3, 8'h3C};        frame_flush();
    wait_idle();

    // matching tag that is itself unsupported, then a plain mismatch
    write_expected_tag(8'hFF);
    frame_bytes = '{TAG_ONES, 8'h00};                   frame_flush();
    frame_bytes = '{8'h01, 8'h00};                      frame_flush();
    wait_idle();
    // mismatch wins over an unsupported tag
    write_expected_tag(TAG_RSVD_80);
    frame_bytes = '{TAG_RSVD_7F};                       frame_flush();
    frame_bytes = '{TAG_RSVD_80, 8'h00};                frame_flush();
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      write_expected_tag(phase_tags[p]);
      src_idle = (p % 3) != 1;
      snk_idle = (p % 3) != 2;
      if (p == 0) begin
        // long receiver hold while a 200 byte value keeps coming
        src_idle = 1'b0;
        hold_req = 250;
        frame_bytes = '{8'h41, LEN_EXT_ONE, 8'hC8};
        frame_junk(200);
        frame_flush();
        wait_idle();
        src_idle = 1'b1;
      end
      while (tx_bytes.size() < 36) random_buffer();
      wait_idle();
      while (tx_bytes.size() < 36) random_buffer();
      wait_idle();
    end

    $display("covered %0d bytes in %0d buffers over six tag settings",
             bytes_sent, buffers_queued);
    $display("%0d results checked, %0d completed TLVs, %0d decode errors",
             results_seen, dones_seen, errors_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ tlv_stream_decoder.f @@
design/tlvsd_pkg.sv
design/tlvsd_if.sv
design/tlvsd_parser.sv
design/tlv_stream_decoder.sv
sim/tlv_stream_decoder_tb.sv
